### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TTF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangle tangent frame check failed");

// Checked on every rising edge, reset included.
`define TTF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("triangle tangent frame check failed");

`endif

### rtl/ttf_pkg.sv
package ttf_pkg;

  // Coordinate and intermediate widths.
  localparam int CW = 32;          // input coordinate, Q16.16
  localparam int DW = CW + 1;      // edge and UV deltas
  localparam int PW = 2 * DW;      // one product of two deltas
  localparam int VW = PW + 2;      // raw tangent, binormal and normal components
  localparam int OW = 16;          // output component
  localparam int OUT_FRAC = 14;    // fraction bits of an output component
  localparam int NORM_BITS = 30;   // significant bits after the common shift
  localparam int SQW = 2 * NORM_BITS;   // square of one component
  localparam int SW = SQW + 2;          // sum of three squares
  localparam int RTW = NORM_BITS + 1;   // integer square root of the sum
  localparam int QW = OUT_FRAC + 1;     // quotient bits
  localparam int NUMW = NORM_BITS + OUT_FRAC + 1;  // dividend
  localparam int NFIELD = 9;

  // Cross-product terms, in issue order.
  localparam int TERM_W = 4;
  localparam logic [TERM_W-1:0] TERM_DET = 4'd0;
  localparam logic [TERM_W-1:0] TERM_TX  = 4'd1;
  localparam logic [TERM_W-1:0] TERM_TY  = 4'd2;
  localparam logic [TERM_W-1:0] TERM_TZ  = 4'd3;
  localparam logic [TERM_W-1:0] TERM_BX  = 4'd4;
  localparam logic [TERM_W-1:0] TERM_BY  = 4'd5;
  localparam logic [TERM_W-1:0] TERM_BZ  = 4'd6;
  localparam logic [TERM_W-1:0] TERM_NX  = 4'd7;
  localparam logic [TERM_W-1:0] TERM_NY  = 4'd8;
  localparam logic [TERM_W-1:0] TERM_NZ  = 4'd9;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAP0,
    OP_CAP1,
    OP_CAP2,
    OP_MUL1,
    OP_MUL2,
    OP_SUB,
    OP_STORE,
    OP_NSTART,
    OP_NSAVE,
    OP_LOAD
  } op_t;

  typedef enum logic [1:0] {
    VSEL_T,
    VSEL_B,
    VSEL_N
  } vsel_t;

  typedef struct packed {
    op_t               op;
    logic [TERM_W-1:0] term;
    vsel_t             sel;
    logic              degen;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic norm_done;
    logic norm_zero;
    logic out_busy;
  } status_t;

endpackage

### rtl/ttf_norm.sv
module ttf_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [ttf_pkg::VW-1:0]  vec_in [3],
  output logic                           done,
  output logic                           zero,
  output logic signed [ttf_pkg::OW-1:0]  res_out [3]
);

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DLOAD,
    N_DIV
  } n_state_t;

  n_state_t                       state;
  logic [ttf_pkg::VW-1:0]         mag [3];
  logic                           neg [3];
  logic [4:0]                     cnt;
  logic [1:0]                     comp;
  logic [ttf_pkg::SQW-1:0]        prod;
  logic [ttf_pkg::SW-1:0]         sum;
  logic [ttf_pkg::SW-1:0]         x;
  logic [ttf_pkg::SW-1:0]         r;
  logic [ttf_pkg::SW-1:0]         b;
  logic [ttf_pkg::RTW-1:0]        rem;
  logic [ttf_pkg::QW-1:0]         numlo;
  logic [ttf_pkg::QW-1:0]         q;

  logic [ttf_pkg::VW-1:0]         comb_or;
  logic [ttf_pkg::NORM_BITS-1:0]  csel;
  logic [ttf_pkg::SW:0]           rb;
  logic [ttf_pkg::RTW-1:0]        root;
  logic [ttf_pkg::NUMW-1:0]       nn;
  logic [ttf_pkg::RTW:0]          trial;
  logic [ttf_pkg::QW-1:0]         qn;
  logic [ttf_pkg::OW-1:0]         qext;

  // Combined magnitude, selected component and one step of each iteration.
  always_comb begin
    comb_or = mag[0] | mag[1] | mag[2];
    case (comp)
      2'd0:    csel = mag[0][ttf_pkg::NORM_BITS-1:0];
      2'd1:    csel = mag[1][ttf_pkg::NORM_BITS-1:0];
      default: csel = mag[2][ttf_pkg::NORM_BITS-1:0];
    endcase
    rb    = {1'b0, r} + {1'b0, b};
    root  = r[ttf_pkg::RTW-1:0];
    nn    = {1'b0, csel, {ttf_pkg::OUT_FRAC{1'b0}}}
            + ttf_pkg::NUMW'(root >> 1);
    trial = {rem, numlo[ttf_pkg::QW-1]};
    qn    = {q[ttf_pkg::QW-2:0], (trial >= {1'b0, root})};
    qext  = {1'b0, qn};
  end

  // Sequencer: common shift, sum of squares, square root, then three divisions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      zero  <= 1'b0;
      cnt   <= '0;
      comp  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec_in[i][ttf_pkg::VW-1];
              mag[i] <= vec_in[i][ttf_pkg::VW-1] ? -vec_in[i] : vec_in[i];
            end
            if (vec_in[0] == '0 && vec_in[1] == '0 && vec_in[2] == '0) begin
              zero <= 1'b1;
              done <= 1'b1;
            end else begin
              zero  <= 1'b0;
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (|comb_or[ttf_pkg::VW-1:ttf_pkg::NORM_BITS]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!comb_or[ttf_pkg::NORM_BITS-1]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            state <= N_SQ;
            cnt   <= '0;
            comp  <= '0;
            sum   <= '0;
          end
        end
        N_SQ: begin
          // One square per cycle; the sum accumulates the registered product.
          prod <= csel * csel;
          comp <= comp + 2'd1;
          cnt  <= cnt + 5'd1;
          if (cnt != 5'd0) begin
            sum <= sum + ttf_pkg::SW'(prod);
          end
          if (cnt == 5'd3) begin
            x     <= sum + ttf_pkg::SW'(prod);
            r     <= '0;
            b     <= ttf_pkg::SW'(1) << (ttf_pkg::SW - 2);
            cnt   <= 5'(ttf_pkg::RTW - 1);
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if ({1'b0, x} >= rb) begin
            x <= x - rb[ttf_pkg::SW-1:0];
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b   <= b >> 2;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            comp  <= '0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem   <= ttf_pkg::RTW'(nn[ttf_pkg::NUMW-1:ttf_pkg::QW]);
          numlo <= nn[ttf_pkg::QW-1:0];
          q     <= '0;
          cnt   <= 5'(ttf_pkg::QW - 1);
          state <= N_DIV;
        end
        N_DIV: begin
          if (trial >= {1'b0, root}) begin
            rem <= ttf_pkg::RTW'(trial - {1'b0, root});
          end else begin
            rem <= trial[ttf_pkg::RTW-1:0];
          end
          q     <= qn;
          numlo <= numlo << 1;
          cnt   <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            res_out[comp] <= neg[comp] ? -qext : qext;
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DLOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

### rtl/ttf_ctrl.sv
module ttf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttf_pkg::status_t status,
  output ttf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM,
    S_NSTART,
    S_NWAIT,
    S_FINISH
  } state_t;

  localparam logic [1:0] PH_V0 = 2'd0;
  localparam logic [1:0] PH_V1 = 2'd1;
  localparam logic [1:0] PH_V2 = 2'd2;

  state_t                     state;
  logic [1:0]                 phase;
  logic [ttf_pkg::TERM_W-1:0] term;
  logic [1:0]                 step;
  ttf_pkg::vsel_t             vsel;
  logic                       degen;

  assign in_ready = (state == S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd.op    = ttf_pkg::OP_IDLE;
    cmd.term  = term;
    cmd.sel   = vsel;
    cmd.degen = degen;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (phase)
            PH_V1:   cmd.op = ttf_pkg::OP_CAP1;
            PH_V2:   cmd.op = ttf_pkg::OP_CAP2;
            default: cmd.op = ttf_pkg::OP_CAP0;
          endcase
        end
      end
      S_TERM: begin
        case (step)
          2'd0:    cmd.op = ttf_pkg::OP_MUL1;
          2'd1:    cmd.op = ttf_pkg::OP_MUL2;
          2'd2:    cmd.op = ttf_pkg::OP_SUB;
          default: cmd.op = ttf_pkg::OP_STORE;
        endcase
      end
      S_NSTART: cmd.op = ttf_pkg::OP_NSTART;
      S_NWAIT: begin
        if (status.norm_done && !status.norm_zero) cmd.op = ttf_pkg::OP_NSAVE;
      end
      S_FINISH: begin
        if (!status.out_busy) cmd.op = ttf_pkg::OP_LOAD;
      end
      default: cmd.op = ttf_pkg::OP_IDLE;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_V0;
      term  <= ttf_pkg::TERM_DET;
      step  <= '0;
      vsel  <= ttf_pkg::VSEL_T;
      degen <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (phase)
              PH_V1: phase <= PH_V2;
              PH_V2: begin
                phase <= PH_V0;
                term  <= ttf_pkg::TERM_DET;
                step  <= '0;
                degen <= 1'b0;
                state <= S_TERM;
              end
              default: phase <= PH_V1;
            endcase
          end
        end
        S_TERM: begin
          step <= step + 2'd1;
          // The determinant is stored by now; a zero one ends the triangle.
          if (term == ttf_pkg::TERM_TX && step == 2'd0 && status.det_zero) begin
            degen <= 1'b1;
            state <= S_FINISH;
          end else if (step == 2'd3) begin
            if (term == ttf_pkg::TERM_BZ) begin
              vsel  <= ttf_pkg::VSEL_T;
              state <= S_NSTART;
            end else if (term == ttf_pkg::TERM_NZ) begin
              vsel  <= ttf_pkg::VSEL_N;
              state <= S_NSTART;
            end else begin
              term <= term + 1'b1;
            end
          end
        end
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (status.norm_done) begin
            if (status.norm_zero) begin
              degen <= 1'b1;
              state <= S_FINISH;
            end else begin
              case (vsel)
                ttf_pkg::VSEL_T: begin
                  vsel  <= ttf_pkg::VSEL_B;
                  state <= S_NSTART;
                end
                ttf_pkg::VSEL_B: begin
                  term  <= ttf_pkg::TERM_NX;
                  step  <= '0;
                  state <= S_TERM;
                end
                default: state <= S_FINISH;
              endcase
            end
          end
        end
        S_FINISH: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ttf_dp.sv
module ttf_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ttf_pkg::cmd_t                         cmd,
  output ttf_pkg::status_t                      status,
  input  logic signed [ttf_pkg::CW-1:0]         vin [5],
  input  logic                                  m_tready,
  output logic                                  out_valid,
  output logic                                  out_degen,
  output logic [ttf_pkg::NFIELD*ttf_pkg::OW-1:0] out_data
);

  logic signed [ttf_pkg::CW-1:0] h0 [5];
  logic signed [ttf_pkg::CW-1:0] h1 [5];
  logic signed [ttf_pkg::DW-1:0] e1 [3];
  logic signed [ttf_pkg::DW-1:0] e2 [3];
  logic signed [ttf_pkg::DW-1:0] du1, dv1, du2, dv2;
  logic signed [ttf_pkg::PW-1:0] prod;
  logic signed [ttf_pkg::VW-1:0] acc;
  logic                          det_zero;
  logic                          det_neg;
  logic signed [ttf_pkg::VW-1:0] tv [3];
  logic signed [ttf_pkg::VW-1:0] bv [3];
  logic signed [ttf_pkg::VW-1:0] nv [3];
  logic signed [ttf_pkg::OW-1:0] tq [3];
  logic signed [ttf_pkg::OW-1:0] bq [3];
  logic signed [ttf_pkg::OW-1:0] nq [3];

  logic signed [ttf_pkg::DW-1:0] a1, b1, a2, b2, opa, opb;
  logic signed [ttf_pkg::DW-1:0] te [3];
  logic signed [ttf_pkg::DW-1:0] be [3];
  logic signed [ttf_pkg::VW-1:0] prod_ext;
  logic signed [ttf_pkg::VW-1:0] acc_adj;
  logic signed [ttf_pkg::VW-1:0] nvec [3];
  logic signed [ttf_pkg::OW-1:0] nres [3];
  logic                          norm_done;
  logic                          norm_zero;

  // Operand selection for the two products of the current term, sign fix of the accumulator and the normalizer input.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      te[i] = {{(ttf_pkg::DW-ttf_pkg::OW){tq[i][ttf_pkg::OW-1]}}, tq[i]};
      be[i] = {{(ttf_pkg::DW-ttf_pkg::OW){bq[i][ttf_pkg::OW-1]}}, bq[i]};
    end
    case (cmd.term)
      ttf_pkg::TERM_DET: begin a1 = du1; b1 = dv2; a2 = du2; b2 = dv1; end
      ttf_pkg::TERM_TX:  begin a1 = dv2; b1 = e1[0]; a2 = dv1; b2 = e2[0]; end
      ttf_pkg::TERM_TY:  begin a1 = dv2; b1 = e1[1]; a2 = dv1; b2 = e2[1]; end
      ttf_pkg::TERM_TZ:  begin a1 = dv2; b1 = e1[2]; a2 = dv1; b2 = e2[2]; end
      ttf_pkg::TERM_BX:  begin a1 = du1; b1 = e2[0]; a2 = du2; b2 = e1[0]; end
      ttf_pkg::TERM_BY:  begin a1 = du1; b1 = e2[1]; a2 = du2; b2 = e1[1]; end
      ttf_pkg::TERM_BZ:  begin a1 = du1; b1 = e2[2]; a2 = du2; b2 = e1[2]; end
      ttf_pkg::TERM_NX:  begin a1 = te[1]; b1 = be[2]; a2 = te[2]; b2 = be[1]; end
      ttf_pkg::TERM_NY:  begin a1 = te[2]; b1 = be[0]; a2 = te[0]; b2 = be[2]; end
      ttf_pkg::TERM_NZ:  begin a1 = te[0]; b1 = be[1]; a2 = te[1]; b2 = be[0]; end
      default:           begin a1 = '0; b1 = '0; a2 = '0; b2 = '0; end
    endcase
    opa = (cmd.op == ttf_pkg::OP_MUL2) ? a2 : a1;
    opb = (cmd.op == ttf_pkg::OP_MUL2) ? b2 : b1;
    prod_ext = {{(ttf_pkg::VW-ttf_pkg::PW){prod[ttf_pkg::PW-1]}}, prod};
    acc_adj  = det_neg ? -acc : acc;
    case (cmd.sel)
      ttf_pkg::VSEL_T: nvec = tv;
      ttf_pkg::VSEL_B: nvec = bv;
      default:         nvec = nv;
    endcase
  end

  // Vertex capture, delta formation, the multiply-accumulate path, result stores and the output load.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ttf_pkg::OP_CAP0: h0 <= vin;
      ttf_pkg::OP_CAP1: h1 <= vin;
      ttf_pkg::OP_CAP2: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= {h1[i][ttf_pkg::CW-1], h1[i]} - {h0[i][ttf_pkg::CW-1], h0[i]};
          e2[i] <= {vin[i][ttf_pkg::CW-1], vin[i]} - {h0[i][ttf_pkg::CW-1], h0[i]};
        end
        du1 <= {h1[3][ttf_pkg::CW-1], h1[3]} - {h0[3][ttf_pkg::CW-1], h0[3]};
        dv1 <= {h1[4][ttf_pkg::CW-1], h1[4]} - {h0[4][ttf_pkg::CW-1], h0[4]};
        du2 <= {vin[3][ttf_pkg::CW-1], vin[3]} - {h0[3][ttf_pkg::CW-1], h0[3]};
        dv2 <= {vin[4][ttf_pkg::CW-1], vin[4]} - {h0[4][ttf_pkg::CW-1], h0[4]};
      end
      ttf_pkg::OP_MUL1: prod <= opa * opb;
      ttf_pkg::OP_MUL2: begin
        acc  <= prod_ext;
        prod <= opa * opb;
      end
      ttf_pkg::OP_SUB: acc <= acc - prod_ext;
      ttf_pkg::OP_STORE: begin
        case (cmd.term)
          ttf_pkg::TERM_DET: det_neg <= acc[ttf_pkg::VW-1];
          ttf_pkg::TERM_TX:  tv[0] <= acc_adj;
          ttf_pkg::TERM_TY:  tv[1] <= acc_adj;
          ttf_pkg::TERM_TZ:  tv[2] <= acc_adj;
          ttf_pkg::TERM_BX:  bv[0] <= acc_adj;
          ttf_pkg::TERM_BY:  bv[1] <= acc_adj;
          ttf_pkg::TERM_BZ:  bv[2] <= acc_adj;
          ttf_pkg::TERM_NX:  nv[0] <= acc;
          ttf_pkg::TERM_NY:  nv[1] <= acc;
          ttf_pkg::TERM_NZ:  nv[2] <= acc;
          default:           nv[0] <= nv[0];
        endcase
      end
      ttf_pkg::OP_NSAVE: begin
        case (cmd.sel)
          ttf_pkg::VSEL_T: tq <= nres;
          ttf_pkg::VSEL_B: bq <= nres;
          default:         nq <= nres;
        endcase
      end
      ttf_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          out_data[i*ttf_pkg::OW +: ttf_pkg::OW]     <= cmd.degen ? '0 : tq[i];
          out_data[(i+3)*ttf_pkg::OW +: ttf_pkg::OW] <= cmd.degen ? '0 : bq[i];
          out_data[(i+6)*ttf_pkg::OW +: ttf_pkg::OW] <= cmd.degen ? '0 : nq[i];
        end
        out_degen <= cmd.degen;
      end
      default: acc <= acc;
    endcase
  end

  // Control flags: determinant test and the result register's valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      det_zero  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ttf_pkg::OP_STORE && cmd.term == ttf_pkg::TERM_DET) begin
        det_zero <= (acc == '0);
      end
      if (cmd.op == ttf_pkg::OP_LOAD) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  ttf_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == ttf_pkg::OP_NSTART),
    .vec_in  (nvec),
    .done    (norm_done),
    .zero    (norm_zero),
    .res_out (nres)
  );

  assign status.det_zero  = det_zero;
  assign status.norm_done = norm_done;
  assign status.norm_zero = norm_zero;
  assign status.out_busy  = out_valid & ~m_tready;

endmodule

### rtl/triangle_tangent_frame_unit.sv
// First and second vertex of a triangle: each is captured, no result.
// Third vertex: determinant, tangent and binormal terms on the shared 33x33 multiplier,
// normalizer passes for tangent and binormal, the normal terms, and a third pass; each
// pass does a shift search, squaring, 31 square-root steps and a division per component.
// A degenerate triangle ends early. The input is taken again once the result is registered.
// Reset (rst, synchronous, active high) clears the sequencer, vertex phase and output valid.
module triangle_tangent_frame_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // tangent_x/y/z, binormal_x/y/z, normal_x/y/z (16 each)
  output logic         m_tuser    // degenerate
);

  ttf_pkg::cmd_t                 cmd;
  ttf_pkg::status_t              status;
  logic signed [ttf_pkg::CW-1:0] vin [5];
  logic                          in_ready;

  // Unpack the vertex fields.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      vin[i] = s_tdata[i*ttf_pkg::CW +: ttf_pkg::CW];
    end
  end

  assign s_tready = in_ready;

  ttf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .vin       (vin),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_degen (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

### rtl/ttf_checker.sv
`include "assert_macros.svh"

module ttf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [159:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic         m_tuser
);

  // No result is offered in the cycle after reset.
  `TTF_ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> !m_tvalid)

  // A degenerate frame carries all-zero vectors.
  `TTF_ASSERT(a_degen_zero, (m_tvalid && m_tuser) |-> (m_tdata == '0))

  // The unit tangent's x component stays within plus or minus one.
  `TTF_ASSERT(a_tangent_range, m_tvalid |-> (($signed(m_tdata[15:0]) <= 16384) && ($signed(m_tdata[15:0]) >= -16384)))

  // A stalled result transaction stays offered.
  `TTF_ASSERT(a_hold_valid, (m_tvalid && !m_tready) |=> m_tvalid)

endmodule

bind triangle_tangent_frame_unit ttf_checker u_ttf_checker (.*);

### bench/tb_triangle_tangent_frame_unit.sv
module tb_triangle_tangent_frame_unit;

  // One expected frame: nine packed Q1.14 components and the degenerate flag.
  typedef struct {
    logic [143:0] frame;
    logic         degen;
  } frame_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each)
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;   // tangent_x/y/z, binormal_x/y/z, normal_x/y/z (16 each)
  logic         m_tuser;   // degenerate

  frame_t expected_frames[$];
  int     errors;
  int     stall_left = 0;
  bit     stalls_on;

  // Vertex store of the predictor.
  longint held_pos[6];
  longint held_tex[4];
  int     vtx_phase;

  triangle_tangent_frame_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Floor of the square root of a sum below 2^62.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Scales a wide vector to unit length in Q1.14; returns 0 for a zero vector.
  function automatic bit unit_vector(input logic signed [127:0] v[3],
                                     output logic signed [15:0] u[3]);
    logic [127:0]    mag[3];
    bit              neg[3];
    longint unsigned c[3];
    longint unsigned sum;
    longint unsigned r;
    longint unsigned q;
    int              top;
    int              len;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][127];
      mag[i] = neg[i] ? -v[i] : v[i];
      len = 0;
      for (int k = 0; k < 128; k++) if (mag[i][k]) len = k + 1;
      if (len > top) top = len;
      u[i] = '0;
    end
    if (top == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (top > ttf_pkg::NORM_BITS) c[i] = 64'(mag[i] >> (top - ttf_pkg::NORM_BITS));
      else c[i] = 64'(mag[i] << (ttf_pkg::NORM_BITS - top));
      sum += c[i] * c[i];
    end
    r = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((c[i] << ttf_pkg::OUT_FRAC) + (r >> 1)) / r;
      u[i] = neg[i] ? -16'(q) : 16'(q);
    end
    return 1'b1;
  endfunction

  // Takes one vertex; on the third vertex of a triangle queues the predicted frame.
  task automatic predict_vertex(input logic [159:0] vtx);
    longint                p[3], e1[3], e2[3];
    longint                tu, tv, du1, dv1, du2, dv2;
    logic signed [127:0]   det;
    logic signed [127:0]   tw[3], bw[3], nw[3];
    logic signed [15:0]    t[3], b[3], n[3];
    bit                    ok;
    frame_t                f;
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(vtx[32*i +: 32]));
    tu = longint'($signed(vtx[96 +: 32]));
    tv = longint'($signed(vtx[128 +: 32]));
    if (vtx_phase == 1) begin
      for (int i = 0; i < 3; i++) held_pos[3 + i] = p[i];
      held_tex[2] = tu;
      held_tex[3] = tv;
      vtx_phase = 2;
      return;
    end
    if (vtx_phase != 2) begin
      for (int i = 0; i < 3; i++) held_pos[i] = p[i];
      held_tex[0] = tu;
      held_tex[1] = tv;
      vtx_phase = 1;
      return;
    end
    vtx_phase = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = held_pos[3 + i] - held_pos[i];
      e2[i] = p[i] - held_pos[i];
    end
    du1 = held_tex[2] - held_tex[0];
    dv1 = held_tex[3] - held_tex[1];
    du2 = tu - held_tex[0];
    dv2 = tv - held_tex[1];
    det = 128'(du1) * 128'(dv2) - 128'(du2) * 128'(dv1);
    ok = (det != 0);
    for (int i = 0; i < 3; i++) begin
      tw[i] = 128'(dv2) * 128'(e1[i]) - 128'(dv1) * 128'(e2[i]);
      bw[i] = 128'(du1) * 128'(e2[i]) - 128'(du2) * 128'(e1[i]);
      if (det < 0) begin
        tw[i] = -tw[i];
        bw[i] = -bw[i];
      end
    end
    if (ok) ok = unit_vector(tw, t);
    if (ok) ok = unit_vector(bw, b);
    if (ok) begin
      nw[0] = 128'(t[1]) * 128'(b[2]) - 128'(t[2]) * 128'(b[1]);
      nw[1] = 128'(t[2]) * 128'(b[0]) - 128'(t[0]) * 128'(b[2]);
      nw[2] = 128'(t[0]) * 128'(b[1]) - 128'(t[1]) * 128'(b[0]);
      ok = unit_vector(nw, n);
    end
    f.frame = '0;
    if (ok) f.frame = {n[2], n[1], n[0], b[2], b[1], b[0], t[2], t[1], t[0]};
    f.degen = !ok;
    expected_frames.push_back(f);
  endtask

  // Sends one vertex after a random gap and waits for the transaction.
  task automatic send_vertex(input logic [31:0] px, py, pz, tu, tv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tv, tu, pz, py, px};
    do @(posedge clk); while (!s_tready);
    predict_vertex({tv, tu, pz, py, px});
  endtask

  task automatic send_triangle(input logic [31:0] v[3][5]);
    for (int i = 0; i < 3; i++) send_vertex(v[i][0], v[i][1], v[i][2], v[i][3], v[i][4]);
  endtask

  task automatic report(input string what, input int idx, input logic [143:0] got,
                        input logic [143:0] want);
    $display("mismatch: %s[%0d] got %h expected %h", what, idx, got, want);
    errors++;
  endtask

  // Result checker and random back-pressure on the master side.
  always @(posedge clk) begin
    frame_t f;
    if (rst) begin
      stall_left <= 0;
      m_tready   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          report("unexpected frame", 0, m_tdata, '0);
        end else begin
          f = expected_frames.pop_front();
          for (int i = 0; i < ttf_pkg::NFIELD; i++)
            if (m_tdata[16*i +: 16] !== f.frame[16*i +: 16])
              report("component", i, m_tdata[16*i +: 16], f.frame[16*i +: 16]);
          if (m_tuser !== f.degen) report("degenerate", 0, m_tuser, f.degen);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
      default: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
    endcase
  endfunction

  // Extremes of the fields, a zero UV determinant, collinear and coincident vertices, tiny deltas.
  task automatic test_directed();
    logic [31:0] v[3][5];
    v = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0},
          '{32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000}};
    send_triangle(v);
    v = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}};
    send_triangle(v);
    // Zero determinant: all three texture coordinates on one line.
    v = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000},
          '{32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0002_0000}};
    send_triangle(v);
    // Collinear positions with a valid determinant: zero normal.
    v = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0},
          '{32'h0003_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000}};
    send_triangle(v);
    // All three vertices identical.
    v = '{'{32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h5, 32'h9},
          '{32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h5, 32'h9},
          '{32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h5, 32'h9}};
    send_triangle(v);
    // A positive determinant: the frame is not flipped.
    v = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          '{32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0},
          '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000}};
    send_triangle(v);
    // Tiny deltas of one least significant bit.
    v = '{'{32'h1, 32'h0, 32'h0, 32'h0, 32'h1},
          '{32'h0, 32'h1, 32'h0, 32'h1, 32'h0},
          '{32'h0, 32'h0, 32'h1, 32'h0, 32'h0}};
    send_triangle(v);
  endtask

  // Random triangles of full-range, mid-range, small and degenerate kinds.
  task automatic test_random(input int count);
    logic [31:0] v[3][5];
    int mode;
    int kind;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 5; k++) v[i][k] = rand_coord(mode);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        v[2][3] = v[0][3];
        v[2][4] = v[0][4];
      end else if (kind == 1) begin
        for (int k = 0; k < 3; k++) v[2][k] = v[1][k];
      end
      send_triangle(v);
    end
  endtask

  // The sender holds off until every queued frame has been taken.
  task automatic test_drain_pause();
    logic [31:0] v[3][5];
    for (int n = 0; n < 4; n++) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 5; k++) v[i][k] = rand_coord(1);
      send_triangle(v);
      s_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    errors     = 0;
    stalls_on  = 1'b0;
    vtx_phase  = 0;
    for (int i = 0; i < 6; i++) held_pos[i] = 0;
    for (int i = 0; i < 4; i++) held_tex[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stalls_on = 1'b1;
    test_drain_pause();
    test_random(120);
    stalls_on = 1'b0;
    test_random(20);
    stalls_on = 1'b1;
    test_random(120);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("triangle_tangent_frame_unit regression: pass");
    end else begin
      $display("triangle_tangent_frame_unit regression: fail");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #10000000;
    $display("triangle_tangent_frame_unit regression: fail");
    $finish;
  end

endmodule

### triangle_tangent_frame_unit.f
+incdir+rtl
rtl/ttf_pkg.sv
rtl/ttf_norm.sv
rtl/ttf_ctrl.sv
rtl/ttf_dp.sv
rtl/triangle_tangent_frame_unit.sv
rtl/ttf_checker.sv
bench/tb_triangle_tangent_frame_unit.sv
